// ===== rtl/cis_pkg.sv =====
// cis_pkg: types and constants for the can identifier statistics table
// request, result and table entry structs, opcode and status codes, controller
// state enum, and the command and status structs between controller and datapath
package cis_pkg;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [28:0] frame_id;
    logic        frame_ext;
    logic        frame_rtr;
    logic [3:0]  frame_len;
    logic [63:0] frame_payload;
    logic [7:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic        read_hit;
    logic [28:0] entry_id;
    logic        entry_ext;
    logic        entry_rtr;
    logic [3:0]  entry_len;
    logic [63:0] entry_payload;
    logic [31:0] entry_count;
    logic [7:0]  entries_used;
    logic [31:0] total_frames;
  } rsp_t;

  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [63:0] payload;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WR_UPD,
    S_WR_NEW,
    S_RD,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic latch_hit;
    logic wr_upd;
    logic wr_new;
    logic drop;
    logic rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_frame;
    logic is_read;
    logic match;
    logic scan_more;
    logic cmp_vld;
    logic full;
  } sts_t;

endpackage

// ===== rtl/cis_ctrl.sv =====
// cis_ctrl: sequencing state machine for the statistics table
// issues commands to cis_dp and reads its status; uses cis_pkg
module cis_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cis_pkg::sts_t sts_i,
  output cis_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          valid_o
);
  import cis_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sts_i.is_frame) begin
            state_d = S_SCAN;
          end else if (sts_i.is_read) begin
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          state_d = S_WR_UPD;
        end else if (!sts_i.scan_more && !sts_i.cmp_vld) begin
          state_d = sts_i.full ? S_FIN : S_WR_NEW;
        end
      end
      S_WR_UPD: state_d = S_FIN;
      S_WR_NEW: state_d = S_FIN;
      S_RD:     state_d = S_FIN;
      S_FIN:    state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b1;
    valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_SCAN: begin
        cmd_o.scan      = !sts_i.match;
        cmd_o.latch_hit = sts_i.match;
        cmd_o.drop      = !sts_i.match && !sts_i.scan_more && !sts_i.cmp_vld && sts_i.full;
      end
      S_WR_UPD: cmd_o.wr_upd = 1'b1;
      S_WR_NEW: cmd_o.wr_new = 1'b1;
      S_RD:     cmd_o.rd     = 1'b1;
      S_FIN:    cmd_o.finish = 1'b1;
      S_DONE:   valid_o      = 1'b1;
      default:  cmd_o        = '0;
    endcase
  end

endmodule

// ===== rtl/cis_dp.sv =====
// cis_dp: datapath of the statistics table
// entry memory, pipelined identifier search, counters and result register; uses cis_pkg
module cis_dp #(
  parameter int unsigned TABLE_DEPTH = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cis_pkg::req_t req_i,
  input  cis_pkg::cmd_t cmd_i,
  output cis_pkg::sts_t sts_o,
  output cis_pkg::rsp_t rsp_o
);
  import cis_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;
  entry_t hit_ent_q;
  entry_t wdata;
  logic [AW-1:0] waddr, raddr;
  logic          we, re;

  req_t          req_q;
  logic [CW-1:0] used_q, used_d;
  logic [31:0]   total_q, total_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic [AW-1:0] hit_idx_q;
  logic [1:0]    status_q, status_d;
  rsp_t          rsp_q, rsp_d;
  logic          scan_more, match, read_hit;

  assign scan_more = scan_idx_q < used_q;
  assign match     = cmp_vld_q && (rdata_q.id == req_q.frame_id);
  assign read_hit  = req_q.read_index < 8'(used_q);

  assign sts_o.is_frame  = req_i.opcode == OP_FRAME;
  assign sts_o.is_read   = req_i.opcode == OP_READ;
  assign sts_o.match     = match;
  assign sts_o.scan_more = scan_more;
  assign sts_o.cmp_vld   = cmp_vld_q;
  assign sts_o.full      = used_q == DepthC;

  always_comb begin
    re    = 1'b0;
    raddr = scan_idx_q[AW-1:0];
    if (cmd_i.scan && scan_more) begin
      re = 1'b1;
    end else if (cmd_i.rd) begin
      re    = read_hit;
      raddr = req_q.read_index[AW-1:0];
    end
  end

  always_comb begin
    we    = cmd_i.wr_upd | cmd_i.wr_new;
    waddr = used_q[AW-1:0];
    wdata.id      = req_q.frame_id;
    wdata.ext     = req_q.frame_ext;
    wdata.rtr     = req_q.frame_rtr;
    wdata.len     = req_q.frame_len;
    wdata.payload = req_q.frame_payload;
    wdata.count   = 32'd1;
    if (cmd_i.wr_upd) begin
      waddr       = hit_idx_q;
      wdata.ext   = hit_ent_q.ext;
      wdata.rtr   = hit_ent_q.rtr;
      wdata.count = hit_ent_q.count + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.latch_hit) begin
      hit_idx_q <= cmp_idx_q;
      hit_ent_q <= rdata_q;
    end
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

  always_comb begin
    used_d     = used_q;
    total_d    = total_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = scan_idx_q[AW-1:0];
    status_d   = status_q;
    if (cmd_i.load) begin
      status_d   = ST_NONE;
      scan_idx_d = '0;
      if (req_i.opcode == OP_FRAME) begin
        total_d = total_q + 32'd1;
      end else if (req_i.opcode == OP_CLEAR) begin
        total_d = '0;
        used_d  = '0;
      end
    end
    if (cmd_i.scan && scan_more) begin
      scan_idx_d = scan_idx_q + CW'(1);
      cmp_vld_d  = 1'b1;
    end
    if (cmd_i.wr_upd) begin
      status_d = ST_UPDATED;
    end
    if (cmd_i.wr_new) begin
      status_d = ST_NEW;
      used_d   = used_q + CW'(1);
    end
    if (cmd_i.drop) begin
      status_d = ST_DROPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      total_q    <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      status_q   <= ST_NONE;
    end else begin
      used_q     <= used_d;
      total_q    <= total_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
      status_q   <= status_d;
    end
  end

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.finish) begin
      rsp_d = '0;
      rsp_d.frame_status = status_q;
      rsp_d.entries_used = 8'(used_q);
      rsp_d.total_frames = total_q;
      if (req_q.opcode == OP_READ && read_hit) begin
        rsp_d.read_hit      = 1'b1;
        rsp_d.entry_id      = rdata_q.id;
        rsp_d.entry_ext     = rdata_q.ext;
        rsp_d.entry_rtr     = rdata_q.rtr;
        rsp_d.entry_len     = rdata_q.len;
        rsp_d.entry_payload = rdata_q.payload;
        rsp_d.entry_count   = rdata_q.count;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/can_id_statistics_table.sv =====
// can_id_statistics_table: top level, controller plus datapath; uses cis_pkg
// a frame scans the used entries until a match (one entry compared per cycle, one memory
// read port), then writes unless dropped; a read fetches its entry; all end in finish and done
// one request at a time; the next is taken the cycle after the strobe
// reset clears the entry count, frame total and controller; table contents stay undefined
// the result strobe lasts one cycle and the receiver cannot stall it
module can_id_statistics_table #(
  parameter int unsigned TABLE_DEPTH = 80
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cis_pkg::req_t req_i,
  output logic          result_valid_o,
  output cis_pkg::rsp_t rsp_o
);
  import cis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (result_valid_o)
  );

  cis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy) else $error("not idle after result");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.entries_used <= 8'(TABLE_DEPTH)))
    else $error("entries_used beyond table depth");

  a_hit_not_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.read_hit) |-> (rsp_o.frame_status == ST_NONE))
    else $error("read hit with frame status");
`endif

endmodule
